>>> rtl/core/rob_pkg.sv
// ----------------------------------------------------------------------------
// rob_pkg: shared types and codes of the RTP reorder buffer
// Result kinds, register indexes, slot record layout and compare unit codes.
// ----------------------------------------------------------------------------
package rob_pkg;

    typedef enum logic [1:0] {
        KIND_PACKET = 2'd0,
        KIND_GAP    = 2'd1,
        KIND_DROP   = 2'd2
    } t_kind;

    localparam logic [1:0] CFG_WAIT   = 2'd0;
    localparam logic [1:0] CFG_IDLE   = 2'd1;
    localparam logic [1:0] CFG_WINDOW = 2'd2;

    // Marker history: known zero, known one, unknown after a gap.
    localparam logic [1:0] PMS_ZERO    = 2'd0;
    localparam logic [1:0] PMS_ONE     = 2'd1;
    localparam logic [1:0] PMS_UNKNOWN = 2'd2;

    typedef enum logic {
        CMP_LATER   = 1'b0,
        CMP_EXCEEDS = 1'b1
    } t_cmp_op;

    typedef struct packed {
        logic [15:0] seq;
        logic        marker;
        logic [31:0] media_time;
        logic [15:0] handle;
        logic [15:0] length;
        logic [31:0] deadline;
    } t_slot;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] seq;
        logic        marker;
        logic [31:0] media_time;
        logic [15:0] handle;
        logic [15:0] length;
    } t_result;

endpackage

>>> rtl/core/rob_ram.sv
// ----------------------------------------------------------------------------
// rob_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rob_ram #(
    parameter int W = 8,
    parameter int D = 32,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/rob_cmp.sv
// ----------------------------------------------------------------------------
// rob_cmp: shared wrap-aware time compare unit
// Answers either "a is strictly later than b" or "a - b exceeds limit".
// ----------------------------------------------------------------------------
module rob_cmp (
    input  rob_pkg::t_cmp_op i_op,
    input  logic [31:0]      i_a,
    input  logic [31:0]      i_b,
    input  logic [15:0]      i_limit,
    output logic             o_hit
);
    import rob_pkg::*;

    logic [31:0] diff;

    assign diff = i_a - i_b;

    always_comb begin
        unique case (i_op)
            CMP_LATER:   o_hit = (diff != 32'd0) && !diff[31];
            CMP_EXCEEDS: o_hit = diff > {16'd0, i_limit};
            default:     o_hit = 1'b0;
        endcase
    end
endmodule

>>> rtl/core/rob_out.sv
// ----------------------------------------------------------------------------
// rob_out: result holding stage
// Holds the latest result back by one so the final one can carry the
// last-of-run flag when the item finishes.
// ----------------------------------------------------------------------------
module rob_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rob_pkg::t_result i_res,
    input  logic             i_flush,
    output logic             o_valid,
    output rob_pkg::t_result o_res,
    output logic             o_last
);
    import rob_pkg::*;

    logic    r_valid, r_pend_v, r_last;
    t_result r_pend, r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_push) begin
                r_valid  <= r_pend_v;
                r_pend_v <= 1'b1;
            end else if (i_flush && r_pend_v) begin
                r_valid  <= 1'b1;
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_pend <= i_res;
            r_out  <= r_pend;
            r_last <= 1'b0;
        end else if (i_flush) begin
            r_out  <= r_pend;
            r_last <= 1'b1;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_out;
    assign o_last  = r_last;
endmodule

>>> rtl/core/rtp_reorder_buffer.sv
// ----------------------------------------------------------------------------
// rtp_reorder_buffer: RTP packet descriptor reorder buffer
// Ring of slots in a RAM, walked by a small sequencer around one compare unit.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  command  | in        | start, busy             | i_action, i_seq_number, ...
//  result   | out       | o_valid strobe          | o_kind ... o_last_of_run
//  config   | in        | i_cfg_we, i_cfg_idx     | i_cfg_data (16 bits)
//
// An item is an arrival or a tick check, either of which may run release passes;
// every slot read goes through the one registered RAM read port.
// Synchronous active-low reset empties the ring at once through the full bits.
// Results are strobed for one cycle each; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rtp_reorder_buffer #(
    parameter int SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [15:0] i_seq_number,
    input  logic        i_marker_bit,
    input  logic [31:0] i_media_time,
    input  logic [15:0] i_payload_handle,
    input  logic [15:0] i_payload_length,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [15:0] o_out_seq,
    output logic        o_out_marker,
    output logic [31:0] o_out_time,
    output logic [15:0] o_out_handle,
    output logic [15:0] o_out_length,
    output logic        o_last_of_run
);
    import rob_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int WW = $clog2(SLOTS + 1);
    localparam int SW = $bits(t_slot);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_ARRIVE = 11'b00000000010,
        S_A_RD   = 11'b00000000100,
        S_A_EV   = 11'b00000001000,
        S_B_RD   = 11'b00000010000,
        S_B_EV   = 11'b00000100000,
        S_C_RD   = 11'b00001000000,
        S_C_EV   = 11'b00010000000,
        S_T_RD   = 11'b00100000000,
        S_T_EV   = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [15:0]      r_wait, r_idle;
    logic [5:0]       r_window;
    logic [SLOTS-1:0] r_full, n_full;
    logic [IW-1:0]    r_head, n_head, r_oldest, n_oldest, r_idx, n_idx;
    logic [WW-1:0]    r_waiting, n_waiting, r_k, n_k, r_res_n, n_res_n;
    logic [WW:0]      r_iter, n_iter;
    logic             r_nsm, n_nsm, r_from_tick, n_from_tick, r_found, n_found;
    logic [1:0]       r_pms, n_pms;
    logic [31:0]      r_prev_time, n_prev_time, r_last_arr, n_last_arr;
    logic [31:0]      r_tick, n_tick, r_best_dl, n_best_dl;
    logic [15:0]      r_prev_seq, n_prev_seq;

    // Latched command
    logic        r_in_mk;
    logic [15:0] r_in_seq, r_in_hd, r_in_len;
    logic [31:0] r_in_time;

    logic [WW-1:0] w_eff;
    logic [6:0]    win_ext;
    logic [IW-1:0] nx, rd_addr, arr_idx, j_idx, b_idx;
    logic [15:0]   seq_dist;
    logic          dist_drop;
    logic [WW:0]   arr_sum, j_sum;
    logic          ram_we;
    t_slot         wr_slot, rd_slot;
    logic          push, flush;
    t_result       res;
    t_result       out_res;
    t_cmp_op       cmp_op;
    logic [31:0]   cmp_a;
    logic          cmp_hit;

    assign win_ext = {1'b0, r_window};
    always_comb begin
        if (r_window == 6'd0) begin
            w_eff = WW'(1);
        end else if (win_ext > 7'(SLOTS)) begin
            w_eff = WW'(SLOTS);
        end else begin
            w_eff = WW'(r_window);
        end
    end

    assign nx = (WW'(r_idx) + WW'(1) == w_eff) ? '0 : r_idx + IW'(1);
    assign b_idx = nx;

    assign seq_dist  = r_in_seq - r_prev_seq;
    assign dist_drop = (seq_dist == 16'd0) || seq_dist[15] || (seq_dist > 16'(w_eff));
    assign arr_sum   = (WW+1)'(r_head) + (WW+1)'(seq_dist[WW-1:0]) - (WW+1)'(1);
    assign arr_idx   = (arr_sum >= (WW+1)'(w_eff)) ? IW'(arr_sum - (WW+1)'(w_eff))
                                                   : IW'(arr_sum);
    assign j_sum     = (WW+1)'(r_head) + (WW+1)'(r_k);
    assign j_idx     = (j_sum >= (WW+1)'(w_eff)) ? IW'(j_sum - (WW+1)'(w_eff))
                                                 : IW'(j_sum);

    assign wr_slot = '{seq: r_in_seq, marker: r_in_mk, media_time: r_in_time,
                       handle: r_in_hd, length: r_in_len,
                       deadline: r_tick + {16'd0, r_wait}};

    always_comb begin
        priority case (1'b1)
            r_state == S_A_RD: rd_addr = r_full[r_idx] ? r_idx : nx;
            r_state == S_B_RD: rd_addr = b_idx;
            r_state == S_C_RD: rd_addr = j_idx;
            default:           rd_addr = r_oldest;
        endcase
    end

    rob_ram #(.W(SW), .D(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (arr_idx),
        .i_wdata (wr_slot),
        .i_raddr (rd_addr),
        .o_rdata (rd_slot)
    );

    assign cmp_op = (r_state == S_T_EV && r_waiting == '0) ? CMP_EXCEEDS : CMP_LATER;
    assign cmp_a  = (r_state == S_C_EV) ? r_best_dl : r_tick;

    rob_cmp u_cmp (
        .i_op    (cmp_op),
        .i_a     (cmp_a),
        .i_b     ((cmp_op == CMP_EXCEEDS) ? r_last_arr : rd_slot.deadline),
        .i_limit (r_idle),
        .o_hit   (cmp_hit)
    );

    always_comb begin
        n_state     = r_state;
        n_full      = r_full;
        n_head      = r_head;
        n_oldest    = r_oldest;
        n_idx       = r_idx;
        n_waiting   = r_waiting;
        n_k         = r_k;
        n_res_n     = r_res_n;
        n_iter      = r_iter;
        n_nsm       = r_nsm;
        n_from_tick = r_from_tick;
        n_found     = r_found;
        n_pms       = r_pms;
        n_prev_time = r_prev_time;
        n_last_arr  = r_last_arr;
        n_tick      = r_tick;
        n_best_dl   = r_best_dl;
        n_prev_seq  = r_prev_seq;
        ram_we      = 1'b0;
        push        = 1'b0;
        flush       = 1'b0;
        res         = '{kind: KIND_GAP, seq: 16'd0, marker: 1'b0,
                        media_time: r_prev_time, handle: 16'd0, length: 16'd0};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res_n = '0;
                    n_iter  = '0;
                    if (i_action) begin
                        n_tick      = r_tick + 32'd1;
                        n_from_tick = 1'b1;
                        n_state     = S_T_RD;
                    end else begin
                        n_from_tick = 1'b0;
                        n_state     = S_ARRIVE;
                    end
                end
            end
            S_ARRIVE: begin
                n_state = S_DONE;
                res = '{kind: KIND_DROP, seq: r_in_seq, marker: r_in_mk,
                        media_time: r_in_time, handle: r_in_hd, length: r_in_len};
                if (r_nsm) begin
                    push        = 1'b1;
                    res.kind    = KIND_PACKET;
                    n_pms       = {1'b0, r_in_mk};
                    n_prev_time = r_in_time;
                    n_prev_seq  = r_in_seq;
                    n_head      = '0;
                    n_oldest    = '0;
                    n_waiting   = '0;
                    n_nsm       = 1'b0;
                    n_last_arr  = r_tick;
                end else if (dist_drop) begin
                    push = 1'b1;
                end else if (r_full[arr_idx]) begin
                    push = 1'b1;
                end else begin
                    ram_we           = 1'b1;
                    n_full[arr_idx]  = 1'b1;
                    n_waiting        = r_waiting + WW'(1);
                    n_last_arr       = r_tick;
                    if (arr_idx == r_head) begin
                        n_oldest = arr_idx;
                        n_idx    = r_head;
                        n_k      = '0;
                        n_state  = S_A_RD;
                    end else if (r_waiting == '0) begin
                        n_oldest = arr_idx;
                    end
                end
            end
            S_A_RD: n_state = S_A_EV;
            S_A_EV: begin
                push = 1'b1;
                if (r_full[r_idx]) begin
                    res = '{kind: KIND_PACKET, seq: rd_slot.seq, marker: rd_slot.marker,
                            media_time: rd_slot.media_time, handle: rd_slot.handle,
                            length: rd_slot.length};
                    n_pms         = {1'b0, rd_slot.marker};
                    n_prev_time   = rd_slot.media_time;
                    n_prev_seq    = rd_slot.seq;
                    n_full[r_idx] = 1'b0;
                    if (r_waiting != '0) n_waiting = r_waiting - WW'(1);
                end else if (r_pms == PMS_ZERO && r_full[nx]
                             && r_prev_time != rd_slot.media_time) begin
                    n_pms      = PMS_ONE;
                    res.marker = 1'b1;
                end else begin
                    n_pms = PMS_UNKNOWN;
                end
                if (r_idx == r_oldest) begin
                    n_k     = '0;
                    n_state = S_B_RD;
                end else begin
                    n_idx = nx;
                    n_k   = r_k + WW'(1);
                    if (r_k + WW'(1) == w_eff) begin
                        n_k     = '0;
                        n_state = S_B_RD;
                    end else begin
                        n_state = S_A_RD;
                    end
                end
            end
            S_B_RD: begin
                // Trailing run of present packets; head to the first hole, if any.
                if (r_k == w_eff || !r_full[b_idx]) begin
                    if (r_k != w_eff) n_head = b_idx;
                    else n_head = r_idx;
                    if (r_k != w_eff) n_idx = b_idx;
                    if (r_waiting == '0) begin
                        n_state = r_from_tick ? S_T_RD : S_DONE;
                    end else begin
                        n_k     = WW'(1);
                        n_found = 1'b0;
                        n_state = S_C_RD;
                    end
                end else begin
                    n_idx   = b_idx;
                    n_state = S_B_EV;
                end
            end
            S_B_EV: begin
                push = 1'b1;
                res = '{kind: KIND_PACKET, seq: rd_slot.seq, marker: rd_slot.marker,
                        media_time: rd_slot.media_time, handle: rd_slot.handle,
                        length: rd_slot.length};
                n_pms         = {1'b0, rd_slot.marker};
                n_prev_time   = rd_slot.media_time;
                n_prev_seq    = rd_slot.seq;
                n_full[r_idx] = 1'b0;
                if (r_waiting != '0) n_waiting = r_waiting - WW'(1);
                n_k     = r_k + WW'(1);
                n_state = S_B_RD;
            end
            S_C_RD: begin
                if (r_full[j_idx]) begin
                    n_idx   = j_idx;
                    n_state = S_C_EV;
                end else if (r_k == w_eff) begin
                    if (!r_found) n_waiting = '0;
                    n_state = r_from_tick ? S_T_RD : S_DONE;
                end else begin
                    n_k = r_k + WW'(1);
                end
            end
            S_C_EV: begin
                if (!r_found || cmp_hit) begin
                    n_oldest  = r_idx;
                    n_best_dl = rd_slot.deadline;
                    n_found   = 1'b1;
                end
                if (r_k == w_eff) begin
                    n_state = r_from_tick ? S_T_RD : S_DONE;
                end else begin
                    n_k     = r_k + WW'(1);
                    n_state = S_C_RD;
                end
            end
            S_T_RD: n_state = S_T_EV;
            S_T_EV: begin
                n_state = S_DONE;
                if (r_nsm) begin
                    n_state = S_DONE;
                end else if (r_iter == (WW+1)'(w_eff) + (WW+1)'(1)) begin
                    n_state = S_DONE;
                end else if (r_waiting == '0) begin
                    if (cmp_hit) n_nsm = 1'b1;
                end else if (!r_full[r_oldest] || cmp_hit) begin
                    n_iter  = r_iter + (WW+1)'(1);
                    n_idx   = r_head;
                    n_k     = '0;
                    n_state = S_A_RD;
                end
            end
            S_DONE: begin
                flush   = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // Results past the per-item limit are suppressed; state still advances.
        if (push) begin
            if (r_res_n < WW'(SLOTS)) begin
                n_res_n = r_res_n + WW'(1);
            end else begin
                push = 1'b0;
            end
        end

        if (i_cfg_we && i_cfg_idx == CFG_WINDOW) begin
            n_full    = '0;
            n_head    = '0;
            n_oldest  = '0;
            n_waiting = '0;
            n_nsm     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 16'd50;
            r_idle      <= 16'd3000;
            r_window    <= 6'd32;
            r_full      <= '0;
            r_head      <= '0;
            r_oldest    <= '0;
            r_waiting   <= '0;
            r_nsm       <= 1'b1;
            r_pms       <= PMS_ZERO;
            r_prev_time <= '0;
            r_prev_seq  <= '0;
            r_last_arr  <= '0;
            r_tick      <= '0;
            r_idx       <= '0;
            r_k         <= '0;
            r_res_n     <= '0;
            r_iter      <= '0;
            r_from_tick <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_full      <= n_full;
            r_head      <= n_head;
            r_oldest    <= n_oldest;
            r_waiting   <= n_waiting;
            r_nsm       <= n_nsm;
            r_pms       <= n_pms;
            r_prev_time <= n_prev_time;
            r_prev_seq  <= n_prev_seq;
            r_last_arr  <= n_last_arr;
            r_tick      <= n_tick;
            r_idx       <= n_idx;
            r_k         <= n_k;
            r_res_n     <= n_res_n;
            r_iter      <= n_iter;
            r_from_tick <= n_from_tick;
            r_found     <= n_found;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WAIT:   r_wait   <= i_cfg_data;
                    CFG_IDLE:   r_idle   <= i_cfg_data;
                    CFG_WINDOW: r_window <= i_cfg_data[5:0];
                    default:    r_wait   <= r_wait;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_dl <= n_best_dl;
        if (r_state == S_IDLE && start) begin
            r_in_seq  <= i_seq_number;
            r_in_mk   <= i_marker_bit;
            r_in_time <= i_media_time;
            r_in_hd   <= i_payload_handle;
            r_in_len  <= i_payload_length;
        end
    end

    rob_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .i_flush (flush),
        .o_valid (o_valid),
        .o_res   (out_res),
        .o_last  (o_last_of_run)
    );

    assign busy         = (r_state != S_IDLE);
    assign o_kind       = out_res.kind;
    assign o_out_seq    = out_res.seq;
    assign o_out_marker = out_res.marker;
    assign o_out_time   = out_res.media_time;
    assign o_out_handle = out_res.handle;
    assign o_out_length = out_res.length;

    a_head_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_head) < w_eff)
        else $error("head slot outside the window");

    a_waiting_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting <= WW'(SLOTS))
        else $error("waiting count above slot count");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_run |=> !o_valid)
        else $error("result strobed straight after the last of a run");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && $past(r_state) == S_IDLE |-> !o_valid)
        else $error("result strobed while idle");
endmodule

>>> test/tb_rtp_reorder_buffer.sv
// ----------------------------------------------------------------------------
// tb_rtp_reorder_buffer: self-checking testbench of the RTP reorder buffer
// Drives packet arrivals and ticks through the command port, predicts every
// released, gap and dropped item and compares each strobed result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rtp_reorder_buffer;
    import rob_pkg::*;

    localparam int NSLOT = 32;

    typedef struct {
        t_kind       kind;
        logic [15:0] seq;
        logic        marker;
        logic [31:0] media_time;
        logic [15:0] handle;
        logic [15:0] length;
        logic        last;
    } t_item;

    // Ordering model of the buffer and the queue of items it predicts.
    class reorder_board;
        t_item       pending[$];
        int          errors;
        logic [15:0] wait_t, idle_t;
        logic [5:0]  win_reg;
        bit          full[NSLOT];
        logic [15:0] s_seq[NSLOT], s_hd[NSLOT], s_len[NSLOT];
        logic        s_mk[NSLOT];
        logic [31:0] s_tm[NSLOT], s_dl[NSLOT];
        int          head, oldest, waiting;
        bit          newseq;
        logic [1:0]  pms;
        logic [31:0] ptime, last_arr, ticks;
        logic [15:0] pseq;
        int          nres;

        function new();
            errors = 0;
            wait_t = 50; idle_t = 3000; win_reg = 32;
            clear_ring();
            pms = PMS_ZERO; ptime = 0; pseq = 0; last_arr = 0; ticks = 0;
        endfunction

        function void clear_ring();
            foreach (full[i]) full[i] = 0;
            head = 0; oldest = 0; waiting = 0; newseq = 1;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] v);
            if (idx == CFG_WAIT) wait_t = v;
            else if (idx == CFG_IDLE) idle_t = v;
            else if (idx == CFG_WINDOW) begin
                win_reg = v[5:0];
                clear_ring();
            end
        endfunction

        function int width();
            if (win_reg < 1) return 1;
            if (win_reg > NSLOT) return NSLOT;
            return win_reg;
        endfunction

        function bit later(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return d != 0 && d < 32'h8000_0000;
        endfunction

        function void push(t_kind k, logic [15:0] sq, logic mk, logic [31:0] tm,
                           logic [15:0] hd, logic [15:0] ln);
            t_item it;
            if (nres >= NSLOT) return;
            it.kind = k; it.seq = sq; it.marker = mk; it.media_time = tm;
            it.handle = hd; it.length = ln; it.last = 0;
            pending.push_back(it);
            nres++;
        endfunction

        function void emit_slot(int i);
            push(KIND_PACKET, s_seq[i], s_mk[i], s_tm[i], s_hd[i], s_len[i]);
            pms = {1'b0, s_mk[i]}; ptime = s_tm[i]; pseq = s_seq[i];
            full[i] = 0;
            if (waiting > 0) waiting--;
        endfunction

        function void flush_head(int w);
            int  idx, nx, j;
            bit  found;
            found = 0;
            idx = head % w;
            for (int k = 0; k < w; k++) begin
                nx = (idx + 1) % w;
                if (full[idx]) emit_slot(idx);
                else if (pms == PMS_ZERO && full[nx] && ptime != s_tm[nx]) begin
                    pms = PMS_ONE;
                    push(KIND_GAP, 0, 1, ptime, 0, 0);
                end else begin
                    pms = PMS_UNKNOWN;
                    push(KIND_GAP, 0, 0, ptime, 0, 0);
                end
                if (idx == oldest) break;
                idx = nx;
            end
            for (int k = 0; k < w; k++) begin
                idx = (idx + 1) % w;
                if (!full[idx]) break;
                emit_slot(idx);
            end
            head = idx;
            if (waiting == 0) return;
            for (int k = 1; k <= w; k++) begin
                j = (head + k) % w;
                if (!full[j]) continue;
                if (!found || later(s_dl[oldest], s_dl[j])) begin
                    oldest = j;
                    found = 1;
                end
            end
            if (!found) waiting = 0;
        endfunction

        // Notes one accepted command and queues the items it causes.
        function void note_command(logic act, logic [15:0] sq, logic mk,
                                   logic [31:0] tm, logic [15:0] hd, logic [15:0] ln);
            int          w, idx;
            logic [15:0] d;
            int          first;
            w = width();
            nres = 0;
            first = pending.size();
            head = head % w; oldest = oldest % w;
            if (act == 1'b0) begin
                if (newseq) begin
                    push(KIND_PACKET, sq, mk, tm, hd, ln);
                    pms = {1'b0, mk}; ptime = tm; pseq = sq;
                    head = 0; oldest = 0; waiting = 0; newseq = 0;
                    last_arr = ticks;
                end else begin
                    d = sq - pseq;
                    if (d == 0 || d >= 16'h8000 || d > w)
                        push(KIND_DROP, sq, mk, tm, hd, ln);
                    else begin
                        idx = (head + d - 1) % w;
                        if (full[idx]) push(KIND_DROP, sq, mk, tm, hd, ln);
                        else begin
                            full[idx] = 1;
                            s_seq[idx] = sq; s_mk[idx] = mk; s_tm[idx] = tm;
                            s_hd[idx] = hd; s_len[idx] = ln;
                            s_dl[idx] = ticks + wait_t;
                            waiting++;
                            last_arr = ticks;
                            if (idx == head) begin
                                oldest = idx;
                                flush_head(w);
                            end else if (waiting == 1) oldest = idx;
                        end
                    end
                end
            end else begin
                ticks++;
                for (int k = 0; k <= w; k++) begin
                    if (newseq) break;
                    if (waiting == 0) begin
                        if (ticks - last_arr > idle_t) newseq = 1;
                        break;
                    end
                    if (!full[oldest] || later(ticks, s_dl[oldest])) flush_head(w);
                    else break;
                end
            end
            if (pending.size() > first) pending[pending.size() - 1].last = 1;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_item got);
            t_item e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result kind %0d seq %0h", got.kind, got.seq));
                return;
            end
            e = pending.pop_front();
            if (got.kind !== e.kind || got.seq !== e.seq || got.marker !== e.marker ||
                got.media_time !== e.media_time || got.handle !== e.handle ||
                got.length !== e.length || got.last !== e.last)
                report($sformatf("got k%0d s%h m%b t%h h%h l%h r%b, want k%0d s%h m%b t%h h%h l%h r%b",
                    got.kind, got.seq, got.marker, got.media_time, got.handle, got.length,
                    got.last, e.kind, e.seq, e.marker, e.media_time, e.handle, e.length,
                    e.last));
        endtask
    endclass

    logic        i_clk, i_rst_n, start, busy;
    logic        i_action, i_marker_bit;
    logic [15:0] i_seq_number, i_payload_handle, i_payload_length;
    logic [31:0] i_media_time;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        o_valid, o_out_marker, o_last_of_run;
    logic [1:0]  o_kind;
    logic [15:0] o_out_seq, o_out_handle, o_out_length;
    logic [31:0] o_out_time;

    rtp_reorder_buffer dut (.*);

    reorder_board board;
    int           idle_pct;
    logic [15:0]  next_seq;
    logic [31:0]  next_ts;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[rtp_reorder_buffer] ERROR");
        $finish;
    end

    // Results are sampled at the rising edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        t_item got;
        if (i_rst_n && o_valid) begin
            got.kind = t_kind'(o_kind); got.seq = o_out_seq; got.marker = o_out_marker;
            got.media_time = o_out_time; got.handle = o_out_handle;
            got.length = o_out_length; got.last = o_last_of_run;
            board.check_result(got);
        end
    end

    // Start is raised on a falling edge after the one it was last dropped on,
    // so the two never land in the same time step.
    task automatic send(logic act, logic [15:0] sq, logic mk, logic [31:0] tm,
                        logic [15:0] hd, logic [15:0] ln);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        start <= 1; i_action <= act; i_seq_number <= sq; i_marker_bit <= mk;
        i_media_time <= tm; i_payload_handle <= hd; i_payload_length <= ln;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_command(act, sq, mk, tm, hd, ln);
        @(negedge i_clk);
        start <= 0;
    endtask

    task automatic tick();
        send(1'b1, 16'($urandom), 1'($urandom), $urandom, 16'($urandom), 16'($urandom));
    endtask

    task automatic pkt(logic [15:0] sq, logic [31:0] tm);
        send(1'b0, sq, 1'($urandom), tm, 16'($urandom), 16'($urandom));
    endtask

    // Waits for every predicted item, then lets the block settle.
    task automatic drain();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        drain();
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.set_reg(idx, v);
    endtask

    // A burst: up to a window plus one packets, shuffled, with strays and ticks.
    task automatic burst(int n);
        logic [15:0] order[$];
        int          j;
        logic [15:0] t;
        for (int k = 0; k < n; k++) order.push_back(16'(next_seq + k));
        for (int k = 0; k < n; k++) begin
            j = $urandom_range(n - 1);
            t = order[k]; order[k] = order[j]; order[j] = t;
        end
        foreach (order[k]) begin
            case ($urandom_range(9))
                0: pkt(16'($urandom), $urandom);
                1: pkt(order[k], next_ts);
                default: ;
            endcase
            if ($urandom_range(9) != 0) pkt(order[k], next_ts + (order[k] >> 1));
            if ($urandom_range(3) == 0) tick();
        end
        next_seq += n;
        next_ts += n;
    endtask

    initial begin
        board = new();
        idle_pct = 0;
        i_rst_n = 0; start = 0; i_action = 0; i_seq_number = 0; i_marker_bit = 0;
        i_media_time = 0; i_payload_handle = 0; i_payload_length = 0;
        i_cfg_we = 0; i_cfg_idx = CFG_WAIT; i_cfg_data = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: first packet passes, extremes, duplicate, behind, far ahead,
        // wrap of sequence number, deadline expiry with gaps and marker recovery.
        send(0, 16'hFFFF, 1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send(0, 16'h0000, 0, 32'h0, 16'h0, 16'h0);
        pkt(16'h0000, 5);
        pkt(16'hFFF0, 5);
        pkt(16'h0030, 5);
        pkt(16'h0003, 7);
        pkt(16'h0003, 7);
        pkt(16'h0005, 9);
        repeat (52) tick();
        pkt(16'h0006, 9);
        pkt(16'h0008, 12);
        pkt(16'h0007, 12);
        write_reg(CFG_WAIT, 16'd0);
        pkt(16'h000B, 1);
        pkt(16'h000A, 2);
        repeat (3) tick();
        write_reg(CFG_IDLE, 16'd1);
        repeat (4) tick();
        pkt(16'h1234, 3);
        write_reg(CFG_WINDOW, 16'd1);
        pkt(16'h0100, 0); pkt(16'h0101, 0); pkt(16'h0102, 0);
        write_reg(CFG_WINDOW, 16'h003F);
        write_reg(CFG_WINDOW, 16'd0);
        pkt(16'h0200, 0); pkt(16'h0202, 0);

        next_seq = $urandom; next_ts = $urandom;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 74;
                2: idle_pct = 0;
                default: idle_pct = 14;
            endcase
            case (ph)
                0: begin
                    write_reg(CFG_WINDOW, 16'd32); write_reg(CFG_WAIT, 16'd6);
                    write_reg(CFG_IDLE, 16'd40);
                end
                2: begin write_reg(CFG_WINDOW, 16'd4); write_reg(CFG_WAIT, 16'hFFFF); end
                4: begin
                    write_reg(CFG_WINDOW, 16'd2); write_reg(CFG_WAIT, 16'd2);
                    write_reg(CFG_IDLE, 16'hFFFF);
                end
                6: begin
                    write_reg(CFG_WINDOW, 16'd17); write_reg(CFG_WAIT, 16'd3);
                    write_reg(CFG_IDLE, 16'd8);
                end
                default: ;
            endcase
            for (int b = 0; b < 2; b++) begin
                burst($urandom_range(1, board.width() + 1));
                repeat ($urandom_range(0, 9)) tick();
                if ($urandom_range(3) == 0) next_seq += $urandom_range(0, 3);
            end
            if (ph == 3) drain();
        end
        // Long idle run so the idle limit starts a fresh sequence.
        write_reg(CFG_IDLE, 16'd2);
        repeat (8) tick();
        pkt(16'h7777, 1);

        drain();
        if (board.errors == 0) $display("[rtp_reorder_buffer] OK");
        else $display("[rtp_reorder_buffer] ERROR");
        $finish;
    end
endmodule
